// ===== rtl/pfu_pkg.sv =====
package pfu_pkg;

    // default slot count
    localparam int NUM_PARTICLES_DEF = 256;

    // configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 31;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TINT_RGB = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIFE_MS  = 3'd4;

    localparam logic [23:0] TINT_RESET = 24'hFFFFFF;
    localparam logic [15:0] LIFE_RESET = 16'd1000;

    // commands
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_SEED   = 1'b1;

    // per-slot particle state
    typedef struct packed {
        logic signed [32:0] birth;
        logic signed [18:0] vx;
        logic signed [18:0] vy;
        logic signed [18:0] vz;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] sz;
    } t_part;

endpackage

// ===== rtl/pfu_state_mem.sv =====
module pfu_state_mem #(
    parameter int NUM_PARTICLES = pfu_pkg::NUM_PARTICLES_DEF,
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  pfu_pkg::t_part    i_wr_data,
    output pfu_pkg::t_part    o_rd_data
);
    import pfu_pkg::*;

    t_part r_mem [NUM_PARTICLES];
    t_part r_rd_q;
    t_part r_byp_data;
    logic  r_byp;

    // state store, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_q     <= r_mem[i_rd_addr];
            r_byp_data <= i_wr_data;
        end
    end

    // bypass when the read hits the slot being written in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (i_rd_en) begin
            r_byp <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : r_rd_q;

endmodule

// ===== rtl/particle_fountain_update_core.sv =====
// particle fountain update core
// input channel (i_in_valid / o_in_ready) carries one word per particle: i_cmd seeds
// (CMD_SEED) or updates (CMD_UPDATE) the slot i_slot; updates use i_now_ms as the timer.
// output channel (o_out_valid / i_out_ready) returns one word per input word, in order:
// position in signed Q16.16, faded colour and the reborn flag.
// configuration: i_cfg_we writes i_cfg_data to register i_cfg_index (base x/y/z, tint,
// lifetime); write only while no word is in flight.
// throughput: one word per cycle while the receiver takes words, set by the one read and
// one write port of the slot store (read at acceptance, written one stage later with a
// bypass for back-to-back hits).
// the nine stages hold the state read, the multiplies, the reciprocal divides and a
// two-bit-per-stage fade divider.
// reset (synchronous, active low) empties the pipeline and loads the register defaults;
// slot contents are undefined until a seed word writes them.
// when the receiver stalls, words collapse into empty stages and o_in_ready stays high
// until every stage is full; nothing is dropped or repeated.
module particle_fountain_update_core #(
    parameter int NUM_PARTICLES = pfu_pkg::NUM_PARTICLES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [pfu_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pfu_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_cmd,
    input  logic [7:0]                      i_slot,
    input  logic [31:0]                     i_now_ms,
    input  logic [15:0]                     i_rand_x,
    input  logic [15:0]                     i_rand_y,
    input  logic [15:0]                     i_rand_z,
    input  logic [15:0]                     i_rand_age,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [31:0]              o_pos_x,
    output logic signed [31:0]              o_pos_y,
    output logic signed [31:0]              o_pos_z,
    output logic [31:0]                     o_argb,
    output logic                            o_reborn
);
    import pfu_pkg::*;

    localparam int ADDR_W = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;
    localparam int NSTAGE = 9;

    // reciprocal constants for the fixed divides
    localparam logic [24:0] RECIP_125  = 25'd17179869;
    localparam logic [6:0]  DIV_125    = 7'd125;
    localparam logic [27:0] RECIP_GRAV = 28'd225179981;
    localparam logic [16:0] GRAV_DIV   = 17'd78125;
    localparam logic signed [18:0] VEL_OFFSET = 19'sd131072;

    typedef struct packed {
        logic [23:0] rem;
        logic [7:0]  q;
    } t_div;

    // one restoring step of the fade divide
    function automatic t_div div_bit(input t_div s, input logic [15:0] d, input logic [2:0] b);
        logic [23:0] dsh;
        t_div        r;
        dsh = {8'b0, d} << b;
        r = s;
        if (s.rem >= dsh) begin
            r.rem  = s.rem - dsh;
            r.q[b] = 1'b1;
        end
        return r;
    endfunction

    // configuration registers
    logic signed [30:0] r_base [3];
    logic [23:0]        r_tint;
    logic [15:0]        r_life;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base[0] <= '0;
            r_base[1] <= '0;
            r_base[2] <= '0;
            r_tint    <= TINT_RESET;
            r_life    <= LIFE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BASE_X:   r_base[0] <= i_cfg_data;
                REG_BASE_Y:   r_base[1] <= i_cfg_data;
                REG_BASE_Z:   r_base[2] <= i_cfg_data;
                REG_TINT_RGB: r_tint    <= i_cfg_data[23:0];
                REG_LIFE_MS:  r_life    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // stage valids and per-stage load enables
    logic [NSTAGE:1]   r_vld;
    logic [NSTAGE+1:1] en;

    always_comb begin
        en[NSTAGE+1] = i_out_ready;
        for (int k = NSTAGE; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= i_in_valid;
            end
            for (int k = 2; k <= NSTAGE; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready = en[1];

    // slot decode
    logic [ADDR_W+7:0] slot_ext;
    logic [ADDR_W-1:0] in_addr;
    logic              in_range;
    logic [31:0]       n_seed_prod;

    assign slot_ext    = (ADDR_W + 8)'(i_slot);
    assign in_addr     = slot_ext[ADDR_W-1:0];
    assign in_range    = slot_ext < (ADDR_W + 8)'(NUM_PARTICLES);
    assign n_seed_prod = i_rand_age * r_life;

    // stage 1: word registered, state read
    logic                r1_cmd;
    logic                r1_in_range;
    logic [ADDR_W-1:0]   r1_addr;
    logic [31:0]         r1_now;
    logic [15:0]         r1_rand [3];
    logic signed [32:0]  r1_seed_birth;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_cmd        <= i_cmd;
            r1_in_range   <= in_range;
            r1_addr       <= in_addr;
            r1_now        <= i_now_ms;
            r1_rand[0]    <= i_rand_x;
            r1_rand[1]    <= i_rand_y;
            r1_rand[2]    <= i_rand_z;
            r1_seed_birth <= 33'sd0 - $signed({17'b0, n_seed_prod[31:16]});
        end
    end

    t_part rd_data;
    t_part wr_data;
    logic  wr_en;

    pfu_state_mem #(
        .NUM_PARTICLES(NUM_PARTICLES),
        .ADDR_W(ADDR_W)
    ) u_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (en[1]),
        .i_rd_addr (in_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (r1_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    // stage 1 logic: age, respawn decision, state write-back
    logic signed [33:0] n_age34;
    logic               n_seed;
    logic               n_respawn;
    logic [15:0]        n_age;
    logic signed [18:0] n_vel_new [3];
    logic signed [31:0] n_start_new [3];

    always_comb begin
        n_seed    = (r1_cmd == CMD_SEED);
        n_age34   = $signed({2'b00, r1_now}) - $signed({rd_data.birth[32], rd_data.birth});
        n_respawn = !n_seed && r1_in_range && (n_age34 > $signed({18'b0, r_life}));
        n_age     = (n_respawn || n_age34[33]) ? 16'd0 : n_age34[15:0];
        n_vel_new[0] = $signed({1'b0, r1_rand[0], 2'b00}) - VEL_OFFSET;
        n_vel_new[1] = $signed({1'b0, r1_rand[1], 2'b00});
        n_vel_new[2] = $signed({1'b0, r1_rand[2], 2'b00}) - VEL_OFFSET;
        for (int k = 0; k < 3; k++) begin
            n_start_new[k] = {r_base[k][30], r_base[k]};
        end
        wr_data.birth = n_seed ? r1_seed_birth : $signed({1'b0, r1_now});
        wr_data.vx    = n_vel_new[0];
        wr_data.vy    = n_vel_new[1];
        wr_data.vz    = n_vel_new[2];
        wr_data.sx    = n_start_new[0];
        wr_data.sy    = n_start_new[1];
        wr_data.sz    = n_start_new[2];
        wr_en = r_vld[1] && en[2] && r1_in_range && (n_seed || n_respawn);
    end

    // stage 2: effective age and motion state
    logic [15:0]        r2_age;
    logic signed [18:0] r2_vel [3];
    logic signed [31:0] r2_start [3];
    logic               r2_zero;
    logic               r2_reborn;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_age       <= n_age;
            r2_vel[0]    <= n_respawn ? n_vel_new[0] : rd_data.vx;
            r2_vel[1]    <= n_respawn ? n_vel_new[1] : rd_data.vy;
            r2_vel[2]    <= n_respawn ? n_vel_new[2] : rd_data.vz;
            r2_start[0]  <= n_respawn ? n_start_new[0] : rd_data.sx;
            r2_start[1]  <= n_respawn ? n_start_new[1] : rd_data.sy;
            r2_start[2]  <= n_respawn ? n_start_new[2] : rd_data.sz;
            r2_zero      <= n_seed || !r1_in_range;
            r2_reborn    <= r1_in_range && (n_seed || n_respawn);
        end
    end

    // stage 3: velocity and gravity products, fade numerator
    logic signed [35:0] r3_p [3];
    logic [31:0]        r3_a2;
    t_div               r3_div;
    logic signed [31:0] r3_start [3];
    logic               r3_zero;
    logic               r3_reborn;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            for (int k = 0; k < 3; k++) begin
                r3_p[k]     <= r2_vel[k] * $signed({1'b0, r2_age});
                r3_start[k] <= r2_start[k];
            end
            r3_a2      <= r2_age * r2_age;
            r3_div.rem <= {r2_age, 8'b0} - 24'(r2_age);
            r3_div.q   <= '0;
            r3_zero    <= r2_zero;
            r3_reborn  <= r2_reborn;
        end
    end

    // stage 4: magnitudes scaled by 1/8, fade bits 7 and 6
    logic [35:0]        n_mag [3];
    logic [30:0]        r4_xa [3];
    logic               r4_neg [3];
    logic [31:0]        r4_a2;
    t_div               r4_div;
    logic signed [31:0] r4_start [3];
    logic               r4_zero;
    logic               r4_reborn;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_mag[k] = r3_p[k][35] ? 36'(-r3_p[k]) : 36'(r3_p[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            for (int k = 0; k < 3; k++) begin
                r4_xa[k]    <= n_mag[k][33:3];
                r4_neg[k]   <= r3_p[k][35];
                r4_start[k] <= r3_start[k];
            end
            r4_a2     <= r3_a2;
            r4_div    <= div_bit(div_bit(r3_div, r_life, 3'd7), r_life, 3'd6);
            r4_zero   <= r3_zero;
            r4_reborn <= r3_reborn;
        end
    end

    // stage 5: reciprocal estimates, fade bits 5 and 4
    logic [55:0]        n_prod [3];
    logic [59:0]        n_gprod;
    logic [24:0]        r5_q0 [3];
    logic [30:0]        r5_xa [3];
    logic               r5_neg [3];
    logic [27:0]        r5_q0g;
    logic [31:0]        r5_a2;
    t_div               r5_div;
    logic signed [31:0] r5_start [3];
    logic               r5_zero;
    logic               r5_reborn;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_prod[k] = 56'(r4_xa[k]) * 56'(RECIP_125);
        end
        n_gprod = 60'(r4_a2) * 60'(RECIP_GRAV);
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            for (int k = 0; k < 3; k++) begin
                r5_q0[k]    <= n_prod[k][55:31];
                r5_xa[k]    <= r4_xa[k];
                r5_neg[k]   <= r4_neg[k];
                r5_start[k] <= r4_start[k];
            end
            r5_q0g    <= n_gprod[59:32];
            r5_a2     <= r4_a2;
            r5_div    <= div_bit(div_bit(r4_div, r_life, 3'd5), r_life, 3'd4);
            r5_zero   <= r4_zero;
            r5_reborn <= r4_reborn;
        end
    end

    // stage 6: remainders of the estimates, fade bits 3 and 2
    logic [30:0]        n_rem [3];
    logic [43:0]        n_remg;
    logic [7:0]         r6_rem [3];
    logic [24:0]        r6_q0 [3];
    logic               r6_neg [3];
    logic [17:0]        r6_remg;
    logic [27:0]        r6_q0g;
    t_div               r6_div;
    logic signed [31:0] r6_start [3];
    logic               r6_zero;
    logic               r6_reborn;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_rem[k] = r5_xa[k] - 31'(32'(r5_q0[k]) * 32'(DIV_125));
        end
        n_remg = {r5_a2, 12'b0} - 44'(r5_q0g) * 44'(GRAV_DIV);
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            for (int k = 0; k < 3; k++) begin
                r6_rem[k]   <= n_rem[k][7:0];
                r6_q0[k]    <= r5_q0[k];
                r6_neg[k]   <= r5_neg[k];
                r6_start[k] <= r5_start[k];
            end
            r6_remg   <= n_remg[17:0];
            r6_q0g    <= r5_q0g;
            r6_div    <= div_bit(div_bit(r5_div, r_life, 3'd3), r_life, 3'd2);
            r6_zero   <= r5_zero;
            r6_reborn <= r5_reborn;
        end
    end

    // stage 7: corrected quotients with sign, fade bits 1 and 0
    logic [24:0]        n_q [3];
    logic signed [25:0] r7_term [3];
    logic [27:0]        r7_gy;
    t_div               r7_div;
    logic signed [31:0] r7_start [3];
    logic               r7_zero;
    logic               r7_reborn;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_q[k] = r6_q0[k] + 25'(r6_rem[k] >= 8'(DIV_125));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            for (int k = 0; k < 3; k++) begin
                r7_term[k]  <= r6_neg[k] ? -$signed({1'b0, n_q[k]}) : $signed({1'b0, n_q[k]});
                r7_start[k] <= r6_start[k];
            end
            r7_gy     <= r6_q0g + 28'(r6_remg >= 18'(GRAV_DIV));
            r7_div    <= div_bit(div_bit(r6_div, r_life, 3'd1), r_life, 3'd0);
            r7_zero   <= r6_zero;
            r7_reborn <= r6_reborn;
        end
    end

    // stage 8: position sums with saturation, fade level
    logic signed [33:0] n_sum [3];
    logic [8:0]         n_ceil;
    logic signed [31:0] r8_pos [3];
    logic [7:0]         r8_fade;
    logic               r8_zero;
    logic               r8_reborn;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_sum[k] = 34'(r7_start[k]) + 34'(r7_term[k]);
        end
        n_sum[1] = n_sum[1] + $signed({6'b0, r7_gy});
        n_ceil = {1'b0, r7_div.q} + 9'(r7_div.rem != '0);
    end

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            for (int k = 0; k < 3; k++) begin
                if (n_sum[k] > 34'sd2147483647) begin
                    r8_pos[k] <= 32'sh7FFFFFFF;
                end else if (n_sum[k] < -34'sd2147483648) begin
                    r8_pos[k] <= 32'sh80000000;
                end else begin
                    r8_pos[k] <= n_sum[k][31:0];
                end
            end
            // zero lifetime only ever sees age zero: full brightness
            r8_fade   <= (r_life == '0) ? 8'd255 : 8'(9'd255 - n_ceil);
            r8_zero   <= r7_zero;
            r8_reborn <= r7_reborn;
        end
    end

    // stage 9: output word, colour scaled by fade
    logic [15:0] n_red;
    logic [15:0] n_grn;
    logic [15:0] n_blu;
    logic signed [31:0] r9_pos [3];
    logic [31:0]        r9_argb;
    logic               r9_reborn;

    always_comb begin
        n_red = r_tint[23:16] * r8_fade;
        n_grn = r_tint[15:8] * r8_fade;
        n_blu = r_tint[7:0] * r8_fade;
    end

    always_ff @(posedge i_clk) begin
        if (en[9]) begin
            for (int k = 0; k < 3; k++) begin
                r9_pos[k] <= r8_zero ? '0 : r8_pos[k];
            end
            r9_argb   <= r8_zero ? '0 : {8'hFF, n_red[15:8], n_grn[15:8], n_blu[15:8]};
            r9_reborn <= r8_reborn;
        end
    end

    assign o_out_valid = r_vld[NSTAGE];
    assign o_pos_x     = r9_pos[0];
    assign o_pos_y     = r9_pos[1];
    assign o_pos_z     = r9_pos[2];
    assign o_argb      = r9_argb;
    assign o_reborn    = r9_reborn;

    // an accepted word lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_vld[1])
        else $error("accepted word missing from first stage");

    // state is written only as a live word leaves the first stage
    a_write_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> r_vld[1] && en[2])
        else $error("state write without a moving word");

    // a held fifth stage keeps its word
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[5] && !en[5] |=> r_vld[5])
        else $error("stalled word lost in mid pipeline");

endmodule

// ===== sim/particle_fountain_checker.sv =====
`timescale 1ns / 1ps

module particle_fountain_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pfu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pfu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic                           i_cmd,
    input  logic [7:0]                     i_slot,
    input  logic [31:0]                    i_now_ms,
    input  logic [15:0]                    i_rand_x,
    input  logic [15:0]                    i_rand_y,
    input  logic [15:0]                    i_rand_z,
    input  logic [15:0]                    i_rand_age,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [31:0]                    i_pos_x,
    input  logic [31:0]                    i_pos_y,
    input  logic [31:0]                    i_pos_z,
    input  logic [31:0]                    i_argb,
    input  logic                           i_reborn,
    output int                             o_fail_count,
    output int                             o_pending
);
    import pfu_pkg::*;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] argb;
        logic        reborn;
    } t_sprite;

    // shadow of the emitter registers and particle store
    longint       emit_x, emit_y, emit_z;
    logic [23:0]  tint;
    logic [15:0]  life;
    t_part        particles [256];
    t_sprite      sprite_queue [$];
    int           fail_count = 0;
    int           pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // fresh velocity and emitter start position
    function automatic void relaunch(int s, logic [15:0] rx, logic [15:0] ry, logic [15:0] rz);
        longint v;
        v = longint'(rx) * 4 - 131072;
        particles[s].vx = v[18:0];
        v = longint'(ry) * 4;
        particles[s].vy = v[18:0];
        v = longint'(rz) * 4 - 131072;
        particles[s].vz = v[18:0];
        particles[s].sx = emit_x[31:0];
        particles[s].sy = emit_y[31:0];
        particles[s].sz = emit_z[31:0];
    endfunction

    function automatic t_sprite advance_particle(logic cmd, logic [7:0] slot, logic [31:0] now,
                                                 logic [15:0] rx, logic [15:0] ry,
                                                 logic [15:0] rz, logic [15:0] ra);
        t_sprite r;
        longint  age, gy, fade, px, py, pz, lf, birth;
        longint  cr, cg, cb;
        int      s;
        r  = '0;
        s  = slot;
        lf = longint'(life);
        if (cmd == CMD_SEED) begin
            relaunch(s, rx, ry, rz);
            birth = -((longint'(ra) * lf) >>> 16);
            particles[s].birth = birth[32:0];
            r.reborn = 1'b1;
            return r;
        end
        age = longint'(now) - longint'($signed(particles[s].birth));
        if (age > lf) begin
            particles[s].birth = {1'b0, now};
            relaunch(s, rx, ry, rz);
            age = 0;
            r.reborn = 1'b1;
        end
        if (age < 0)
            age = 0;
        gy = (age * age * 262144) / 5000000;
        px = clamp32(longint'($signed(particles[s].sx))
                     + (longint'($signed(particles[s].vx)) * age) / 1000);
        py = clamp32(longint'($signed(particles[s].sy))
                     + (longint'($signed(particles[s].vy)) * age) / 1000 + gy);
        pz = clamp32(longint'($signed(particles[s].sz))
                     + (longint'($signed(particles[s].vz)) * age) / 1000);
        if (lf == 0)
            fade = 255;
        else
            fade = 255 - (age * 255 + lf - 1) / lf;
        if (fade < 0)
            fade = 0;
        cr = (longint'(tint[23:16]) * fade) >> 8;
        cg = (longint'(tint[15:8]) * fade) >> 8;
        cb = (longint'(tint[7:0]) * fade) >> 8;
        r.pos_x = px[31:0];
        r.pos_y = py[31:0];
        r.pos_z = pz[31:0];
        r.argb  = {8'hFF, cr[7:0], cg[7:0], cb[7:0]};
        return r;
    endfunction

    function automatic void report(string field, logic [31:0] want, logic [31:0] got);
        fail_count++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endfunction

    // watch config writes, accepted words and returned words
    always @(posedge i_clk) begin
        t_sprite want;
        if (!i_rst_n) begin
            emit_x = 0;
            emit_y = 0;
            emit_z = 0;
            tint   = TINT_RESET;
            life   = LIFE_RESET;
            sprite_queue.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_BASE_X:   emit_x = longint'($signed(i_cfg_data[30:0]));
                    REG_BASE_Y:   emit_y = longint'($signed(i_cfg_data[30:0]));
                    REG_BASE_Z:   emit_z = longint'($signed(i_cfg_data[30:0]));
                    REG_TINT_RGB: tint   = i_cfg_data[23:0];
                    REG_LIFE_MS:  life   = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                sprite_queue.push_back(advance_particle(i_cmd, i_slot, i_now_ms, i_rand_x,
                                                        i_rand_y, i_rand_z, i_rand_age));
            if (i_out_valid && i_out_ready) begin
                if (sprite_queue.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected word, actual pos %h %h %h argb %h reborn %b",
                             $time, i_pos_x, i_pos_y, i_pos_z, i_argb, i_reborn);
                end else begin
                    want = sprite_queue.pop_front();
                    if (i_pos_x !== want.pos_x) report("pos_x", want.pos_x, i_pos_x);
                    if (i_pos_y !== want.pos_y) report("pos_y", want.pos_y, i_pos_y);
                    if (i_pos_z !== want.pos_z) report("pos_z", want.pos_z, i_pos_z);
                    if (i_argb !== want.argb) report("argb", want.argb, i_argb);
                    if (i_reborn !== want.reborn)
                        report("reborn", 32'(want.reborn), 32'(i_reborn));
                end
            end
        end
        pending_count = sprite_queue.size();
    end

endmodule

// ===== sim/particle_fountain_update_core_tb.sv =====
`timescale 1ns / 1ps

module particle_fountain_update_core_tb;
    import pfu_pkg::*;

    localparam int CYCLE_LIMIT = 900000;
    localparam int WORDS_PER_PHASE = 400;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_cmd = CMD_UPDATE;
    logic [7:0]            i_slot = '0;
    logic [31:0]           i_now_ms = '0;
    logic [15:0]           i_rand_x = '0;
    logic [15:0]           i_rand_y = '0;
    logic [15:0]           i_rand_z = '0;
    logic [15:0]           i_rand_age = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic signed [31:0]    o_pos_x, o_pos_y, o_pos_z;
    logic [31:0]           o_argb;
    logic                  o_reborn;

    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int          stall_left = 0;
    bit          receiver_calm = 1'b0;
    bit          seeded [256];
    logic [31:0] clock_ms;
    int          life_now;

    particle_fountain_update_core DUT (.*);

    particle_fountain_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_ready(o_in_ready), .i_cmd, .i_slot, .i_now_ms,
        .i_rand_x, .i_rand_y, .i_rand_z, .i_rand_age,
        .i_out_valid(o_out_valid), .i_out_ready, .i_pos_x(o_pos_x), .i_pos_y(o_pos_y),
        .i_pos_z(o_pos_z), .i_argb(o_argb), .i_reborn(o_reborn),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** particle_fountain_update_core: FAILED **");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else begin
            i_out_ready <= 1'b1;
            if (!receiver_calm && $urandom_range(0, 3) == 0)
                stall_left <= pick_gap();
        end
    end

    task automatic send_word(logic cmd, logic [7:0] slot, logic [31:0] now,
                             logic [15:0] rx, logic [15:0] ry, logic [15:0] rz,
                             logic [15:0] ra, int gap);
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_slot     <= slot;
        i_now_ms   <= now;
        i_rand_x   <= rx;
        i_rand_y   <= ry;
        i_rand_z   <= rz;
        i_rand_age <= ra;
        do @(posedge i_clk); while (!o_in_ready);
        if (cmd == CMD_SEED)
            seeded[slot] = 1'b1;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // caller drops the write enable after the last write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        if (idx == REG_LIFE_MS)
            life_now = data[15:0];
    endtask

    task automatic emitter_setup(logic [30:0] bx, logic [30:0] by, logic [30:0] bz,
                                 logic [23:0] tint, logic [15:0] life);
        wait_drained();
        write_reg(REG_BASE_X, bx);
        write_reg(REG_BASE_Y, by);
        write_reg(REG_BASE_Z, bz);
        write_reg(REG_TINT_RGB, 31'(tint));
        write_reg(REG_LIFE_MS, 31'(life));
        i_cfg_we <= 1'b0;
    endtask

    // mostly a creeping timer over seeded slots, with seeds and timer jumps mixed in
    task automatic random_phase(int count);
        logic [7:0]  slot;
        logic        cmd;
        logic [31:0] now;
        for (int n = 0; n < count; n++) begin
            slot = 8'($urandom_range(0, 255));
            cmd  = (!seeded[slot] || $urandom_range(0, 7) == 0) ? CMD_SEED : CMD_UPDATE;
            clock_ms = clock_ms + 32'($urandom_range(0, life_now / 4 + 1));
            if ($urandom_range(0, 9) == 0)
                now = $urandom;
            else if ($urandom_range(0, 19) == 0)
                now = clock_ms - 32'($urandom_range(1, 2 * life_now + 1));
            else
                now = clock_ms;
            send_word(cmd, slot, now, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), pick_gap());
        end
    endtask

    initial begin
        life_now = LIFE_RESET;
        clock_ms = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, boundary ages, respawn and timer behind birth
        send_word(CMD_SEED, 8'd0, 32'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
        send_word(CMD_SEED, 8'd255, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
        send_word(CMD_SEED, 8'd1, 32'd0, 16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA, 0);
        send_word(CMD_UPDATE, 8'd0, 32'd0, 16'h0, 16'h0, 16'h0, 16'h0, 0);
        send_word(CMD_UPDATE, 8'd0, 32'd500, 16'h0, 16'h0, 16'h0, 16'h0, 0);
        send_word(CMD_UPDATE, 8'd0, 32'd1000, 16'h0, 16'h0, 16'h0, 16'h0, 0);
        send_word(CMD_UPDATE, 8'd0, 32'd1001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0, 0);
        send_word(CMD_UPDATE, 8'd0, 32'd1500, 16'h0, 16'h0, 16'h0, 16'h0, 0);
        send_word(CMD_UPDATE, 8'd0, 32'd2, 16'h0, 16'h0, 16'h0, 16'h0, 0);
        send_word(CMD_UPDATE, 8'd255, 32'd1, 16'h0, 16'h0, 16'h0, 16'h0, 0);
        send_word(CMD_UPDATE, 8'd255, 32'hFFFFFFFF, 16'h1234, 16'hFFFF, 16'h0, 16'h0, 0);
        send_word(CMD_UPDATE, 8'd255, 32'd0, 16'h0, 16'h0, 16'h0, 16'h0, 0);
        send_word(CMD_UPDATE, 8'd1, 32'd999, 16'h0, 16'h0, 16'h0, 16'h0, 0);
        send_word(CMD_UPDATE, 8'd1, 32'd1000, 16'h0, 16'h0, 16'h0, 16'h0, 3);

        // extreme emitter, shortest nonzero life
        emitter_setup(31'h3FFFFFFF, 31'h3FFFFFFF, 31'h3FFFFFFF, 24'hFFFFFF, 16'd1);
        send_word(CMD_SEED, 8'd2, 32'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
        send_word(CMD_UPDATE, 8'd2, 32'd1, 16'h0, 16'h0, 16'h0, 16'h0, 0);
        send_word(CMD_UPDATE, 8'd2, 32'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0, 0);
        random_phase(WORDS_PER_PHASE);

        // sender holds off until everything is back
        wait_drained();

        // opposite extreme, longest life, black tint
        emitter_setup(31'h40000000, 31'h40000000, 31'h40000000, 24'h000000, 16'd65535);
        send_word(CMD_SEED, 8'd3, 32'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
        send_word(CMD_UPDATE, 8'd3, 32'd65535, 16'h0, 16'h0, 16'h0, 16'h0, 0);
        random_phase(WORDS_PER_PHASE);

        // random emitter, quiet receiver for a while
        emitter_setup(31'($urandom), 31'($urandom), 31'($urandom), 24'($urandom),
                      16'($urandom_range(50, 3000)));
        receiver_calm = 1'b1;
        random_phase(WORDS_PER_PHASE / 2);
        receiver_calm = 1'b0;
        random_phase(WORDS_PER_PHASE / 2);

        emitter_setup(31'($urandom), 31'($urandom), 31'($urandom), 24'h80FF01, 16'd1000);
        random_phase(WORDS_PER_PHASE);

        wait_drained();
        if (fail_count == 0 && pending == 0)
            $display("** particle_fountain_update_core: PASSED **");
        else
            $display("** particle_fountain_update_core: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/pfu_pkg.sv
rtl/pfu_state_mem.sv
rtl/particle_fountain_update_core.sv
sim/particle_fountain_checker.sv
sim/particle_fountain_update_core_tb.sv
